// ----- rtl/wga_pkg.sv -----
// Shared types, constants and helpers for the weighted Gram accumulator.
`default_nettype none
package wga_pkg;

    localparam int DIM = 9;
    localparam int NENT = DIM * (DIM + 1) / 2;
    localparam int IDX_W = 6;
    localparam int SUM_W = 56;
    localparam int CNT_W = 32;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_ACC  = 2'd0,
        OP_WACC = 2'd1,
        OP_READ = 2'd2,
        OP_CLR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] j0;
        logic signed [15:0] j1;
        logic signed [15:0] j2;
        logic signed [15:0] j3;
        logic signed [15:0] j4;
        logic signed [15:0] j5;
        logic signed [15:0] j6;
        logic signed [15:0] j7;
        logic signed [15:0] j8;
        logic [16:0]        weight;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]        entry_index;
        logic signed [SUM_W-1:0] entry_sum;
        logic [CNT_W-1:0]        sample_count;
        logic                    last;
    } out_beat_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        op_t                op;
        logic signed [DIM-1:0] [15:0] jv;
        logic [16:0]        weight;
    } cmd_t;

    // Row and column of each upper-triangle entry, row-major.
    function automatic logic [3:0] ent_row(input logic [IDX_W-1:0] k);
        logic [3:0] r;
        int unsigned cnt;
        r = '0;
        cnt = 0;
        for (int a = 0; a < DIM; a++) begin
            for (int b = a; b < DIM; b++) begin
                if (cnt == k) r = 4'(a);
                cnt++;
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] ent_col(input logic [IDX_W-1:0] k);
        logic [3:0] c;
        int unsigned cnt;
        c = '0;
        cnt = 0;
        for (int a = 0; a < DIM; a++) begin
            for (int b = a; b < DIM; b++) begin
                if (cnt == k) c = 4'(b);
                cnt++;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/wga_front.sv -----
// Front end: accepts input beats and queues classified commands.
`default_nettype none
module wga_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wga_pkg::in_beat_t   in_data,
    output logic                cmd_valid,
    input  wire                 cmd_take,
    output wga_pkg::cmd_t       cmd
);
    import wga_pkg::*;

    cmd_t       q_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    cmd_t       c_new;

    // Classify the beat into a command.
    always_comb
    begin
        c_new.op = op_t'(in_data.op);
        c_new.jv[0] = in_data.j0;
        c_new.jv[1] = in_data.j1;
        c_new.jv[2] = in_data.j2;
        c_new.jv[3] = in_data.j3;
        c_new.jv[4] = in_data.j4;
        c_new.jv[5] = in_data.j5;
        c_new.jv[6] = in_data.j6;
        c_new.jv[7] = in_data.j7;
        c_new.jv[8] = in_data.j8;
        c_new.weight = in_data.weight;
    end

    assign in_stall  = (cnt_reg == 2'(QDEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rp_reg];

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= c_new;
    end
endmodule
`default_nettype wire

// ----- rtl/wga_back.sv -----
// Back end: sweeps the 45 sums for accumulate and read commands, and clears them all for a clear command.
`default_nettype none
module wga_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_take,
    input  wga_pkg::cmd_t       cmd,
    output logic                out_valid,
    input  wire                 out_stall,
    output wga_pkg::out_beat_t  out_data
);
    import wga_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    state_t                  state_reg;
    logic [IDX_W-1:0]        k_reg;
    logic                    stg_reg;
    cmd_t                    c_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    valid_reg [NENT];
    logic signed [SUM_W-1:0] mem [NENT];
    logic signed [SUM_W-1:0] rd_reg;
    logic signed [31:0]      prod_reg;
    logic signed [49:0]      wp;
    logic signed [SUM_W:0]   sum_w;
    logic signed [SUM_W-1:0] cur, add_v, sat_v;
    logic [3:0]              ra, cb;
    logic                    ov_reg;
    logic                    emit;
    out_beat_t               ob_reg;

    assign ra = ent_row(k_reg);
    assign cb = ent_col(k_reg);
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid = ov_reg;
    assign out_data = ob_reg;

    // A read step loads the output register when it is free or draining.
    assign emit = (state_reg == S_RUN) && stg_reg && (c_reg.op == OP_READ)
                  && (!ov_reg || !out_stall);

    // Weighted product and saturating add on the staged product.
    always_comb
    begin
        cur = valid_reg[k_reg] ? rd_reg : '0;
        wp  = 50'(prod_reg) * $signed({1'b0, c_reg.weight});
        if (c_reg.op == OP_WACC) add_v = SUM_W'(wp >>> 16);
        else add_v = SUM_W'(prod_reg);
        sum_w = {cur[SUM_W-1], cur} + {add_v[SUM_W-1], add_v};
        if (sum_w[SUM_W] != sum_w[SUM_W-1])
            sat_v = sum_w[SUM_W] ? SMIN : SMAX;
        else sat_v = sum_w[SUM_W-1:0];
    end

    // Sequencer: a two-phase step per entry (read and multiply, then write, or emit for a read).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            stg_reg   <= 1'b0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NENT; i++) valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (emit) ov_reg <= 1'b1;
            else if (ov_reg && !out_stall) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        k_reg   <= '0;
                        stg_reg <= 1'b0;
                        if (cmd.op == OP_CLR)
                        begin
                            cnt_reg <= '0;
                            for (int i = 0; i < NENT; i++) valid_reg[i] <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_RUN;
                            if (cmd.op != OP_READ && cnt_reg != '1)
                                cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_RUN:
                begin
                    if (!stg_reg) stg_reg <= 1'b1;
                    else if (c_reg.op == OP_READ)
                    begin
                        if (emit)
                        begin
                            stg_reg <= 1'b0;
                            if (k_reg == IDX_W'(NENT - 1)) state_reg <= S_IDLE;
                            else k_reg <= k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        valid_reg[k_reg] <= 1'b1;
                        stg_reg <= 1'b0;
                        if (k_reg == IDX_W'(NENT - 1)) state_reg <= S_IDLE;
                        else k_reg <= k_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers, memory read and write.
    always_ff @(posedge clk)
    begin
        if (cmd_take) c_reg <= cmd;
        if (state_reg == S_RUN && !stg_reg)
        begin
            rd_reg   <= mem[k_reg];
            prod_reg <= $signed(c_reg.jv[ra]) * $signed(c_reg.jv[cb]);
        end
        if (state_reg == S_RUN && stg_reg)
        begin
            if (c_reg.op == OP_READ)
            begin
                if (emit)
                begin
                    ob_reg.entry_index  <= k_reg;
                    ob_reg.entry_sum    <= cur;
                    ob_reg.sample_count <= cnt_reg;
                    ob_reg.last         <= (k_reg == IDX_W'(NENT - 1));
                end
            end
            else mem[k_reg] <= sat_v;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/weighted_gram_accumulator_9.sv -----
// Top level of the weighted Gram accumulator.
// Each accumulate beat updates all 45 upper-triangle sums of the 9x9 normal matrix
// by walking one entry at a time through a single 16x16 multiplier, a weight
// multiplier and a saturating adder on one memory port, reading and multiplying an
// entry and then writing it back; a read emits 45 beats, holding while the output
// is stalled, and a clear resets all sums and the sample count. A two-entry command queue
// lets the input side accept beats while the back end is busy.
`default_nettype none
module weighted_gram_accumulator_9 (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wga_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output wga_pkg::out_beat_t  out_data
);
    import wga_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    wga_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    wga_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // The back end only takes a command the queue offers.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");

    // The last flag marks only the final entry.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.entry_index == IDX_W'(NENT - 1))
        else $error("last flag on wrong entry");

    // A stalled output beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_stall) |-> out_valid && $stable(out_data))
        else $error("stalled beat changed");
endmodule
`default_nettype wire

// ----- bench/tb_weighted_gram_accumulator_9.sv -----
// Self-checking testbench for the weighted Gram accumulator.
`timescale 1ns / 1ps
`default_nettype none
module tb_weighted_gram_accumulator_9;
    import wga_pkg::*;

    localparam int MAX_QUIET = 40000;
    localparam logic signed [55:0] SUM_HI = {1'b0, {55{1'b1}}};
    localparam logic signed [55:0] SUM_LO = {1'b1, {55{1'b0}}};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_beat_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_beat_t  out_data;

    weighted_gram_accumulator_9 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Model state of the normal matrix and the sample counter.
    logic signed [55:0] gram_sum [NENT];
    logic [31:0]        sample_total;

    in_beat_t   pending_rows [$];
    out_beat_t  expected_entries [$];
    int         error_count;
    int         quiet_cycles;
    bit         stimulus_done;
    bit         calm_phase;
    int         send_gap;
    int         recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Apply one accepted beat to the model and queue any read-out entries.
    task automatic predict_gram(input in_beat_t b);
        logic signed [15:0]  jr [DIM];
        logic signed [31:0]  prod;
        logic signed [63:0]  scaled;
        logic signed [57:0]  acc;
        out_beat_t           e;
        int                  k;
        jr = '{b.j0, b.j1, b.j2, b.j3, b.j4, b.j5, b.j6, b.j7, b.j8};
        k = 0;
        case (op_t'(b.op))
            OP_ACC, OP_WACC:
            begin
                for (int a = 0; a < DIM; a++)
                begin
                    for (int c = a; c < DIM; c++)
                    begin
                        prod = jr[a] * jr[c];
                        if (op_t'(b.op) == OP_WACC)
                        begin
                            scaled = 64'(prod) * $signed({47'd0, b.weight});
                            scaled = scaled >>> 16;
                        end
                        else
                            scaled = 64'(prod);
                        acc = 58'(gram_sum[k]) + 58'(scaled);
                        if (acc > 58'(SUM_HI))
                            gram_sum[k] = SUM_HI;
                        else if (acc < 58'(SUM_LO))
                            gram_sum[k] = SUM_LO;
                        else
                            gram_sum[k] = acc[55:0];
                        k++;
                    end
                end
                if (sample_total != 32'hFFFF_FFFF)
                    sample_total++;
            end
            OP_CLR:
            begin
                foreach (gram_sum[i]) gram_sum[i] = '0;
                sample_total = '0;
            end
            default:
            begin
                for (int i = 0; i < NENT; i++)
                begin
                    e.entry_index = IDX_W'(i);
                    e.entry_sum = gram_sum[i];
                    e.sample_count = sample_total;
                    e.last = (i == NENT - 1);
                    expected_entries.push_back(e);
                end
            end
        endcase
    endtask

    function automatic in_beat_t make_row(input op_t o, input int mode);
        in_beat_t b;
        logic [15:0] v [DIM];
        for (int i = 0; i < DIM; i++)
        begin
            case (mode)
                0: v[i] = 16'h8000;
                1: v[i] = 16'h7FFF;
                2: v[i] = 16'(($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF);
                default: v[i] = 16'($urandom);
            endcase
        end
        b.op = o;
        {b.j0, b.j1, b.j2, b.j3, b.j4, b.j5, b.j6, b.j7, b.j8} =
            {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        case ($urandom_range(0, 5))
            0: b.weight = 17'd0;
            1: b.weight = 17'd65536;
            2: b.weight = 17'h1FFFF;
            default: b.weight = 17'($urandom);
        endcase
        return b;
    endfunction

    // Stimulus: directed corners, then mostly accumulate runs ended by reads.
    initial
    begin
        in_beat_t b;
        int n;
        foreach (gram_sum[i]) gram_sum[i] = '0;
        sample_total = '0;
        error_count = 0;
        stimulus_done = 1'b0;
        calm_phase = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        pending_rows.push_back(make_row(OP_READ, 3));
        b = make_row(OP_ACC, 0);
        pending_rows.push_back(b);
        pending_rows.push_back(make_row(OP_ACC, 1));
        b = make_row(OP_WACC, 0);
        b.weight = 17'd65536;
        pending_rows.push_back(b);
        b.weight = 17'h1FFFF;
        pending_rows.push_back(b);
        b = make_row(OP_WACC, 2);
        b.weight = 17'd0;
        pending_rows.push_back(b);
        b = make_row(OP_WACC, 3);
        b.weight = 17'd1;
        pending_rows.push_back(b);
        pending_rows.push_back(make_row(OP_READ, 3));
        pending_rows.push_back(make_row(OP_CLR, 3));
        pending_rows.push_back(make_row(OP_READ, 3));
        // Push all sums toward saturation with large same-sign rows.
        for (int i = 0; i < 10; i++)
        begin
            b = make_row(OP_WACC, 0);
            b.weight = 17'h1FFFF;
            pending_rows.push_back(b);
        end
        pending_rows.push_back(make_row(OP_READ, 3));
        pending_rows.push_back(make_row(OP_CLR, 3));

        n = 0;
        while (n < 98)
        begin
            int run_len;
            run_len = $urandom_range(1, 6);
            for (int i = 0; i < run_len; i++)
            begin
                pending_rows.push_back(make_row(op_t'($urandom_range(0, 1)),
                                                ($urandom_range(0, 5) == 0) ? 2 : 3));
                n++;
            end
            pending_rows.push_back(make_row(OP_READ, 3));
            n++;
            if ($urandom_range(0, 4) == 0)
            begin
                pending_rows.push_back(make_row(OP_CLR, 3));
                n++;
            end
        end

        wait (pending_rows.size() == 0 && !in_valid);
        stimulus_done = 1'b1;
    end

    // Calm tail: the last stretch runs without idling on either side.
    always @(posedge clk)
        if (rst_n && pending_rows.size() < 15)
            calm_phase <= 1'b1;

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_gram(in_data);
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_rows.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_rows.pop_front();
                if (!calm_phase && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall bursts and result checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_entries.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    out_beat_t e;
                    e = expected_entries.pop_front();
                    if (out_data.entry_index !== e.entry_index)
                        report_mismatch($sformatf("entry_index %0d, expected %0d",
                                                  out_data.entry_index, e.entry_index));
                    if (out_data.entry_sum !== e.entry_sum)
                        report_mismatch($sformatf("entry %0d sum %0d, expected %0d",
                                                  e.entry_index, out_data.entry_sum,
                                                  e.entry_sum));
                    if (out_data.sample_count !== e.sample_count)
                        report_mismatch($sformatf("sample_count %0d, expected %0d",
                                                  out_data.sample_count, e.sample_count));
                    if (out_data.last !== e.last)
                        report_mismatch($sformatf("last %0b on entry %0d",
                                                  out_data.last, e.entry_index));
                end
            end
            if (recv_gap > 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                recv_gap <= $urandom_range(0, 6);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // End of run.
    initial
    begin
        wait (rst_n);
        wait ((stimulus_done && expected_entries.size() == 0) || quiet_cycles >= MAX_QUIET);
        if (quiet_cycles >= MAX_QUIET)
        begin
            $display("Verification failed");
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (error_count == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
